@@ rtl/core/rcta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rcta_pkg;

  // field widths
  localparam int unsigned IntW  = 31;
  localparam int unsigned FracW = 32;
  localparam int unsigned BaseW = 5;
  localparam int unsigned CharW = 7;
  localparam int unsigned DigitW = 4;

  // sizes
  localparam int unsigned FRAC_BITS   = 32;
  localparam int unsigned FRAC_DIGITS = 3;
  localparam int unsigned STACK_DEPTH = 32;

  localparam int unsigned StackAw   = $clog2(STACK_DEPTH);
  localparam int unsigned DepthW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FracCntW  = $clog2(FRAC_DIGITS + 1);

  // divider: DivSteps quotient bits per cycle
  localparam int unsigned DivSteps  = 8;
  localparam int unsigned DivCycles = (IntW + DivSteps - 1) / DivSteps;
  localparam int unsigned DivW      = DivCycles * DivSteps;
  localparam int unsigned StepW     = (DivCycles > 1) ? $clog2(DivCycles) : 1;

  // command queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // radix limits
  localparam logic [BaseW-1:0] BaseMin = BaseW'(2);
  localparam logic [BaseW-1:0] BaseMax = BaseW'(16);

  // ascii codes
  localparam logic [CharW-1:0] CharZero = 7'h30;
  localparam logic [CharW-1:0] CharA    = 7'h41;
  localparam logic [CharW-1:0] CharDot  = 7'h2E;
  localparam logic [CharW-1:0] CharNone = 7'h00;
  localparam logic [DigitW-1:0] DigitTen = 4'd10;

  typedef struct packed {
    logic [IntW-1:0]  integer_part;
    logic [FracW-1:0] fraction_part;
    logic [BaseW-1:0] base;
    logic             bad;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StPopRd,
    StPopWr,
    StDot,
    StFrac
  } back_state_e;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DigitTen) begin
      c = CharZero + CharW'(d);
    end else begin
      c = CharA + CharW'(d - DigitTen);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rcta_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rcta_front
  import rcta_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [IntW-1:0]  integer_part_i,
  input  wire logic [FracW-1:0] fraction_part_i,
  input  wire logic [BaseW-1:0] base_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output cmd_t                  cmd_o
);

  cmd_t             queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push, pop;
  cmd_t             cmd_in;

  // classify: flag radix outside the supported range
  always_comb begin
    cmd_in.integer_part  = integer_part_i;
    cmd_in.fraction_part = fraction_part_i;
    cmd_in.base          = base_i;
    cmd_in.bad           = (base_i < BaseMin) || (base_i > BaseMax);
  end

  assign in_ready_o  = (count_q != QCntW'(QDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rcta_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rcta_back
  import rcta_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire cmd_t              cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CharW-1:0]       character_o,
  output logic                   last_char_o,
  output logic                   bad_base_o
);

  back_state_e           state_q, state_d;
  logic [DivW-1:0]       quo_q, quo_d;
  logic [DigitW-1:0]     rem_q, rem_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [DepthW-1:0]     depth_q, depth_d;
  logic [FRAC_BITS-1:0]  fr_q, fr_d;
  logic [BaseW-1:0]      base_q, base_d;
  logic [FracCntW-1:0]   fcnt_q, fcnt_d;

  logic                  out_valid_q, out_valid_d;
  logic [CharW-1:0]      out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic                  out_bad_q, out_bad_d;

  logic [DigitW-1:0]     stack_mem [STACK_DEPTH];
  logic [DigitW-1:0]     rd_data_q;
  logic                  push_en, rd_en;
  logic [StackAw-1:0]    rd_addr;

  logic                  out_free;
  logic                  step_last;
  logic                  frac_last;
  logic [DivW-1:0]       div_quo;
  logic [BaseW-1:0]      div_rem;
  logic [FRAC_BITS+BaseW-1:0] prod;

  assign out_free  = !out_valid_q || out_ready_i;
  assign step_last = (step_q == StepW'(DivCycles - 1));
  assign frac_last = (fcnt_q == FracCntW'(FRAC_DIGITS - 1));
  assign rd_addr   = StackAw'(depth_q - 1'b1);
  assign prod      = (FRAC_BITS + BaseW)'(fr_q) * (FRAC_BITS + BaseW)'(base_q);

  // restoring division, DivSteps quotient bits per cycle, msb first
  always_comb begin
    logic [BaseW-1:0] r;
    logic [DivW-1:0]  q;
    r = BaseW'(rem_q);
    q = quo_q;
    for (int i = 0; i < DivSteps; i++) begin
      r = {r[BaseW-2:0], q[DivW-1]};
      q = {q[DivW-2:0], 1'b0};
      if (r >= base_q) begin
        r    = r - base_q;
        q[0] = 1'b1;
      end
    end
    div_quo = q;
    div_rem = r;
  end

  assign cmd_ready_o = (state_q == StIdle) && (!cmd_i.bad || out_free);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && !cmd_i.bad) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (step_last && (div_quo == '0)) begin
          state_d = StPopRd;
        end
      end
      StPopRd: begin
        state_d = StPopWr;
      end
      StPopWr: begin
        if (out_free) begin
          state_d = (depth_q == '0) ? StDot : StPopRd;
        end
      end
      StDot: begin
        if (out_free) begin
          state_d = StFrac;
        end
      end
      StFrac: begin
        if (out_free && frac_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and result register
  always_comb begin
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    depth_d     = depth_q;
    fr_d        = fr_q;
    base_d      = base_q;
    fcnt_d      = fcnt_q;
    push_en     = 1'b0;
    rd_en       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && cmd_ready_o) begin
          if (cmd_i.bad) begin
            out_valid_d = 1'b1;
            out_char_d  = CharNone;
            out_last_d  = 1'b1;
            out_bad_d   = 1'b1;
          end else begin
            quo_d   = DivW'(cmd_i.integer_part);
            rem_d   = '0;
            step_d  = '0;
            depth_d = '0;
            fr_d    = FRAC_BITS'(cmd_i.fraction_part);
            base_d  = cmd_i.base;
            fcnt_d  = '0;
          end
        end
      end
      StDiv: begin
        quo_d  = div_quo;
        rem_d  = DigitW'(div_rem);
        step_d = step_q + 1'b1;
        if (step_last) begin
          rem_d  = '0;
          step_d = '0;
          // digits past a full stack are dropped
          if (depth_q < DepthW'(STACK_DEPTH)) begin
            push_en = 1'b1;
            depth_d = depth_q + 1'b1;
          end
        end
      end
      StPopRd: begin
        rd_en   = 1'b1;
        depth_d = depth_q - 1'b1;
      end
      StPopWr: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(rd_data_q);
          out_last_d  = 1'b0;
          out_bad_d   = 1'b0;
        end
      end
      StDot: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CharDot;
          out_last_d  = 1'b0;
          out_bad_d   = 1'b0;
        end
      end
      StFrac: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(prod[FRAC_BITS +: DigitW]);
          out_last_d  = frac_last;
          out_bad_d   = 1'b0;
          fr_d        = prod[FRAC_BITS-1:0];
          fcnt_d      = fcnt_q + 1'b1;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      depth_q     <= '0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      depth_q     <= depth_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    fr_q       <= fr_d;
    base_q     <= base_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  // digit stack
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[depth_q[StackAw-1:0]] <= DigitW'(div_rem);
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = out_char_q;
  assign last_char_o = out_last_q;
  assign bad_base_o  = out_bad_q;

`ifndef SYNTH
  a_bad_word_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_base_o) |-> (last_char_o && (character_o == CharNone)))
    else $error("error word malformed");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(STACK_DEPTH))
    else $error("stack depth overflow");

  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (BaseW'(rem_q) < base_q))
    else $error("partial remainder not below radix");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPopRd) |-> (depth_q != '0))
    else $error("pop from empty digit stack");
`endif

endmodule

`default_nettype wire

@@ rtl/core/radix_conversion_to_ascii.sv @@
`timescale 1ns / 1ps
`default_nettype none

// radix conversion of a fixed-point number to an ascii digit string
// - input channel (in_valid_i / in_ready_o): one word carries integer_part,
//   fraction_part (scaled by 2^32) and base; base must lie in 2..16
// - output channel (out_valid_o / out_ready_i): one word per character, most
//   significant integer digit first, then '.', then three fraction digits;
//   last_char_o marks the final fraction digit
// - a base outside 2..16 yields one word: character 0, last_char and bad_base set
// - per number, the back end runs the divider once per integer digit, pops the
//   digits from the stack, emits '.', then the fraction digits; it takes the
//   next number only once the last character of the previous one is in the
//   result register; each integer digit passes through the shared 8-bit-per-cycle
//   divider, and a pop goes through a read state and a write state (registered
//   read); each fraction digit takes one 32x5 multiply
// - a bad-base word goes from the idle state straight into the result register
// - a two-word command queue sits between the classifying front end and the
//   back end, so new words are taken while a number is still being converted
// - when the receiver stalls, the result register holds its word and the
//   back end waits; the queue keeps accepting until full
// - reset clears the queue, the sequencer and the result valid; no clearing
//   pass is needed
module radix_conversion_to_ascii
  import rcta_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [IntW-1:0]  integer_part_i,
  input  wire logic [FracW-1:0] fraction_part_i,
  input  wire logic [BaseW-1:0] base_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CharW-1:0]      character_o,
  output logic                  last_char_o,
  output logic                  bad_base_o
);

  // classified command between the two halves
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // front end: accept and classify, queue commands
  rcta_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .integer_part_i  (integer_part_i),
    .fraction_part_i (fraction_part_i),
    .base_i          (base_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  // back end: divide, stack, multiply, emit characters
  rcta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_char_o (last_char_o),
    .bad_base_o  (bad_base_o)
  );

endmodule

`default_nettype wire

@@ tb/ascii_string_checker.sv @@
`timescale 1ns / 1ps

module ascii_string_checker
  import rcta_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [IntW-1:0]  integer_part_i,
  input  logic [FracW-1:0] fraction_part_i,
  input  logic [BaseW-1:0] base_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [CharW-1:0] character_i,
  input  logic             last_char_i,
  input  logic             bad_base_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam int unsigned MaxPrinted = 40;
  localparam logic [63:0] FracMask   = (64'd1 << FRAC_BITS) - 64'd1;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last_char;
    logic             bad_base;
  } char_word_t;

  char_word_t expected_chars[$];
  char_word_t want;

  function automatic logic [CharW-1:0] ascii_of(input logic [DigitW-1:0] d);
    return (d < DigitTen) ? CharZero + CharW'(d) : CharA + CharW'(d - DigitTen);
  endfunction

  // expected character string of one number, most significant first
  function automatic void predict_digit_string(input logic [IntW-1:0]  whole_in,
                                               input logic [FracW-1:0] frac_in,
                                               input logic [BaseW-1:0] radix);
    logic [IntW-1:0]   whole;
    logic [63:0]       frac;
    logic [63:0]       prod;
    logic [DigitW-1:0] stack [STACK_DEPTH];
    int unsigned       depth;
    int unsigned       k;
    char_word_t        w;
    if (radix < BaseMin || radix > BaseMax) begin
      w = '{CharNone, 1'b1, 1'b1};
      expected_chars.push_back(w);
      return;
    end
    // division digits, least significant first; a zero part still gives one digit
    whole = whole_in;
    depth = 0;
    do begin
      if (depth < STACK_DEPTH) begin
        stack[depth] = DigitW'(whole % IntW'(radix));
        depth++;
      end
      whole = whole / IntW'(radix);
    end while (whole != '0);
    while (depth > 0) begin
      depth--;
      w = '{ascii_of(stack[depth]), 1'b0, 1'b0};
      expected_chars.push_back(w);
    end
    w = '{CharDot, 1'b0, 1'b0};
    expected_chars.push_back(w);
    // fraction digits by exact multiply and truncate
    frac = 64'(frac_in) & FracMask;
    for (k = 0; k < FRAC_DIGITS; k++) begin
      prod = frac * 64'(radix);
      w = '{ascii_of(DigitW'(prod >> FRAC_BITS)), (k == FRAC_DIGITS - 1), 1'b0};
      expected_chars.push_back(w);
      frac = prod & FracMask;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [CharW-1:0] seen,
                                 input logic [CharW-1:0] wanted);
    if (fail_count_o < MaxPrinted) begin
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, seen, wanted);
    end
    fail_count_o++;
  endtask

  // sampled on the falling edge: all signals are settled for the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i === 1'b1 && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("word with nothing expected", character_i, CharNone);
        end else begin
          want = expected_chars.pop_front();
          if (character_i !== want.character) begin
            report_mismatch("character", character_i, want.character);
          end
          if (last_char_i !== want.last_char) begin
            report_mismatch("last_char", CharW'(last_char_i), CharW'(want.last_char));
          end
          if (bad_base_i !== want.bad_base) begin
            report_mismatch("bad_base", CharW'(bad_base_i), CharW'(want.bad_base));
          end
        end
      end
      if (in_valid_i && in_ready_i === 1'b1) begin
        predict_digit_string(integer_part_i, fraction_part_i, base_i);
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rcta_pkg::*;

  localparam int unsigned RandomWords = 480;
  // worst case is a number of 35 words, each behind a long stall; the limit
  // leaves a wide margin above that
  localparam int unsigned RunLimit    = 3_000_000;
  // the longest number has 31 binary integer digits
  localparam int unsigned DrainCycles = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [IntW-1:0]  integer_part = '0;
  logic [FracW-1:0] fraction_part = '0;
  logic [BaseW-1:0] base = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CharW-1:0] character;
  logic             last_char;
  logic             bad_base;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned ready_hold;
  // no idling on either side while set
  logic        quiet = 1'b0;

  always #2 clk = ~clk;

  radix_conversion_to_ascii i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .integer_part_i (integer_part),
    .fraction_part_i(fraction_part),
    .base_i         (base),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .character_o    (character),
    .last_char_o    (last_char),
    .bad_base_o     (bad_base)
  );

  ascii_string_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .integer_part_i (integer_part),
    .fraction_part_i(fraction_part),
    .base_i         (base),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .character_i    (character),
    .last_char_i    (last_char),
    .bad_base_i     (bad_base),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet) begin
      return 0;
    end else if (roll < 65) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  // receiver: alternates ready bursts with stalls of random length
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      ready_hold <= pick_gap();
      if (ready_hold == 0 && $urandom_range(0, 1) == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ~out_ready;
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RunLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one word after an optional gap, return at the edge that takes it
  task automatic send_number(input logic [IntW-1:0] ip, input logic [FracW-1:0] fr,
                             input logic [BaseW-1:0] radix);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    integer_part  <= ip;
    fraction_part <= fr;
    base          <= radix;
    // ready is settled at the falling edge; the word goes at the next rising edge
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
  endtask

  initial begin
    int unsigned      roll;
    int unsigned      pick;
    logic [IntW-1:0]  ip;
    logic [FracW-1:0] fr;
    logic [BaseW-1:0] radix;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero and full-scale fields, every radix but 6, exact products
    send_number(0, 0, 10);
    send_number('1, '1, BaseMin);               // 31 binary digits, the longest string
    send_number('1, '1, BaseMax);
    send_number('1, 0, 10);
    send_number(0, 32'h8000_0000, BaseMin);     // exact half: one digit then zero padding
    send_number(0, 32'h4000_0000, 4);
    send_number(255, 32'hC000_0000, BaseMax);
    send_number(12345, 32'h2000_0000, 8);
    send_number(10, 0, 11);                     // single letter digit
    send_number(15, 32'hFFFF_FFFF, BaseMax);
    send_number(1, 32'hFFFF_FFFF, 3);
    send_number(100, 32'h5555_5555, 3);
    send_number(31'h2AAA_AAAA, 32'hAAAA_AAAA, 5);
    send_number(999, 32'h0000_0001, 7);
    send_number(4096, 32'h1234_5678, 9);
    send_number(123456789, 32'h8000_0000, 12);  // half times twelve is whole
    send_number(77, 32'hE000_0000, 13);
    send_number(31'h5555_5555, 32'h5555_5555, 14);
    send_number(7, 32'h3000_0000, 15);
    // radix out of range: one flagged word each
    send_number('1, '1, 0);
    send_number(0, 0, 1);
    send_number(5, 32'h8000_0000, 17);
    send_number(123, 456, 31);

    for (int unsigned n = 0; n < RandomWords; n++) begin
      // switch between idling and back-to-back stretches
      if (n % 60 == 0) begin
        quiet <= ($urandom_range(0, 3) == 0);
      end
      // once, let the block drain completely before going on
      if (n == RandomWords / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        ip = '0;
      end else if (roll < 16) begin
        ip = '1;
      end else begin
        // spread the magnitude so short and long digit strings both occur
        ip = IntW'($urandom) >> $urandom_range(0, IntW - 1);
      end

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        fr = '0;
      end else if (roll < 14) begin
        fr = FracW'($urandom_range(0, 15)) << (FracW - 4);
      end else if (roll < 18) begin
        fr = '1;
      end else begin
        fr = $urandom;
      end

      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        radix = BaseW'($urandom_range(BaseMin, BaseMax));
      end else begin
        // invalid radix: 0, 1 or 17..31
        pick  = $urandom_range(0, 16);
        radix = (pick < 2) ? BaseW'(pick) : BaseW'(pick + 15);
      end

      send_number(ip, fr, radix);
    end

    in_valid <= 1'b0;
    quiet    <= 1'b0;
    while (pending != 0) @(posedge clk);
    // catch stray words after the last expected one
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rcta_pkg.sv
rtl/core/rcta_front.sv
rtl/core/rcta_back.sv
rtl/core/radix_conversion_to_ascii.sv
tb/ascii_string_checker.sv
tb/testbench.sv
